[hw/rtl/i2cdws_pkg.sv]
// Types, constants and symbol decode shared by the DAC write sequencer files.
package i2cdws_pkg;

  localparam int unsigned IdxW = 6;
  localparam logic [IdxW-1:0] LastIdx = 6'd48;
  localparam logic [7:0] HighByteMark = 8'hC0;

  typedef enum logic [1:0] {
    SymStart = 2'd0,
    SymData  = 2'd1,
    SymAck   = 2'd2,
    SymStop  = 2'd3
  } sym_kind_e;

  typedef enum logic [1:0] {
    SelAddr = 2'd0,
    SelHigh = 2'd1,
    SelLow  = 2'd2,
    SelCmd  = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic [7:0]  command_byte;
    logic [11:0] dac_code;
    logic [7:0]  device_address;
  } req_t;

  typedef struct packed {
    sym_kind_e symbol_kind;
    logic      bit_value;
    logic      last_symbol;
  } sym_t;

  typedef struct packed {
    sym_kind_e kind;
    byte_sel_e sel;
    logic [2:0] pos;
  } sym_dec_t;

  // Position in the 49-symbol frame to kind, source byte and bit (MSB first).
  function automatic sym_dec_t sym_decode(logic [IdxW-1:0] idx);
    sym_dec_t d;
    logic [IdxW-1:0] top;
    d.kind = SymData;
    d.sel  = SelAddr;
    top    = '0;
    case (idx) inside
      6'd0, 6'd29:       d.kind = SymStart;
      6'd28:             d.kind = SymStop;
      6'd9, 6'd18, 6'd27, 6'd38, 6'd47: d.kind = SymAck;
      [6'd1:6'd8]:   begin d.sel = SelAddr; top = 6'd8;  end
      [6'd10:6'd17]: begin d.sel = SelHigh; top = 6'd17; end
      [6'd19:6'd26]: begin d.sel = SelLow;  top = 6'd26; end
      [6'd30:6'd37]: begin d.sel = SelAddr; top = 6'd37; end
      [6'd39:6'd46]: begin d.sel = SelCmd;  top = 6'd46; end
      default:           d.kind = SymStop;
    endcase
    d.pos = 3'(top - idx);
    return d;
  endfunction

endpackage

[hw/rtl/i2c_dac_write_sequencer_core.sv]
// Top level: turns one DAC write request into the bus symbols of two I2C writes.
// The request is registered with the busy flag first; the first symbol then enters the output register.
// Throughput: one symbol per cycle from the symbol counter, 49 symbols per request;
//   the next request is taken in the cycle the final stop enters the output register.
// Output stalls hold the counter, so the rate follows the downstream ready.
// Reset (rst_ni low, asynchronous): sequencer idle, no symbol pending.
module i2c_dac_write_sequencer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2cdws_pkg::req_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2cdws_pkg::sym_t   out_data_o
);
  import i2cdws_pkg::*;

  // Held request and position in its symbol frame
  req_t            req_q;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // Output register: parts the symbol generator from the downstream ready
  logic out_valid_q, out_valid_d;
  sym_t out_q, out_d;

  sym_dec_t   dec;
  logic [7:0] cur_byte;
  logic       advance;     // a symbol moves into the output register this cycle
  logic       take;        // request transaction

  assign advance = busy_q && (!out_valid_q || out_ready_i);
  // Free once idle, or while the final stop is being issued
  assign in_ready_o = !busy_q || (advance && (idx_q == LastIdx));
  assign take = in_valid_i && in_ready_o;

  assign dec = sym_decode(idx_q);

  always_comb begin
    case (dec.sel)
      SelAddr: cur_byte = req_q.device_address;
      SelHigh: cur_byte = HighByteMark | {4'h0, req_q.dac_code[11:8]};
      SelLow:  cur_byte = req_q.dac_code[7:0];
      default: cur_byte = req_q.command_byte;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d       = 1'b1;
      out_d.symbol_kind = dec.kind;
      out_d.bit_value   = (dec.kind == SymAck) ||
                          ((dec.kind == SymData) && cur_byte[dec.pos]);
      out_d.last_symbol = (idx_q == LastIdx);
      idx_d             = idx_q + 1'b1;
      if (idx_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (take) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (take) begin
      req_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/i2cdws_checker.sv]
// Port-level checker for the DAC write sequencer, bound to the top level.
module i2cdws_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input i2cdws_pkg::req_t in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input i2cdws_pkg::sym_t out_data_o
);
  import i2cdws_pkg::*;

  // A pending symbol holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output symbol changed under stall");

  a_last_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_symbol |-> out_data_o.symbol_kind == SymStop)
    else $error("last symbol is not a stop");

  a_ack_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.symbol_kind == SymAck |-> out_data_o.bit_value)
    else $error("ack slot does not release SDA");

  a_cond_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.symbol_kind == SymStart ||
                    out_data_o.symbol_kind == SymStop) |-> !out_data_o.bit_value)
    else $error("start or stop with bit value set");

  // A waiting request holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while waiting");

endmodule

bind i2c_dac_write_sequencer_core i2cdws_checker u_i2cdws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[test/i2cdws_symbol_checker.sv]
`timescale 1ns / 100ps
// Checker for the DAC write sequencer: predicts each request's bus symbols and compares them.
module i2cdws_symbol_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  i2cdws_pkg::req_t in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  i2cdws_pkg::sym_t out_data_i,
  output int               fail_count_o,
  output int               pending_syms_o
);
  import i2cdws_pkg::*;

  sym_t            bus_sym_q[$];
  logic [27:0]     held_req  = '0;
  int              fails     = 0;
  int              pending   = 0;
  int unsigned     sym_no    = 0;

  assign fail_count_o   = fails;
  assign pending_syms_o = pending;

  task automatic push_sym(input sym_kind_e kind, input logic bit_v, input logic last);
    sym_t s;
    s.symbol_kind = kind;
    s.bit_value   = bit_v;
    s.last_symbol = last;
    bus_sym_q.push_back(s);
  endtask

  // eight data bits MSB first, then a released ack slot
  task automatic push_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      push_sym(SymData, b[i], 1'b0);
    end
    push_sym(SymAck, 1'b1, 1'b0);
  endtask

  // code write then command write; only the closing stop carries the last flag
  task automatic queue_write_frames(input req_t r);
    held_req  = r;
    push_sym(SymStart, 1'b0, 1'b0);
    push_byte(held_req[7:0]);
    push_byte(HighByteMark | {4'h0, held_req[19:16]});
    push_byte(held_req[15:8]);
    push_sym(SymStop, 1'b0, 1'b0);
    push_sym(SymStart, 1'b0, 1'b0);
    push_byte(held_req[7:0]);
    push_byte(held_req[27:20]);
    push_sym(SymStop, 1'b0, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sym_t want;
    if (!rst_ni) begin
      bus_sym_q.delete();
      held_req  = '0;
    end else begin
      // drain before filling: a symbol taken on this edge belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (bus_sym_q.size() == 0) begin
          $error("symbol %0d with nothing expected: symbol_kind %0d bit_value %0d last_symbol %0d",
                 sym_no, out_data_i.symbol_kind, out_data_i.bit_value,
                 out_data_i.last_symbol);
          fails++;
        end else begin
          want = bus_sym_q.pop_front();
          if (out_data_i.symbol_kind !== want.symbol_kind) begin
            $error("symbol %0d symbol_kind: expected %0d, got %0d",
                   sym_no, want.symbol_kind, out_data_i.symbol_kind);
            fails++;
          end
          if (out_data_i.bit_value !== want.bit_value) begin
            $error("symbol %0d bit_value: expected %0d, got %0d",
                   sym_no, want.bit_value, out_data_i.bit_value);
            fails++;
          end
          if (out_data_i.last_symbol !== want.last_symbol) begin
            $error("symbol %0d last_symbol: expected %0d, got %0d",
                   sym_no, want.last_symbol, out_data_i.last_symbol);
            fails++;
          end
        end
        sym_no++;
      end
      if (in_valid_i && in_ready_i) begin
        queue_write_frames(in_data_i);
      end
    end
    pending = bus_sym_q.size();
  end

endmodule

[test/tb_i2c_dac_write_sequencer_core.sv]
`timescale 1ns / 100ps
// Testbench top for the I2C DAC write sequencer: clock, reset, request stimulus and verdict.
module tb_i2c_dac_write_sequencer_core;
  import i2cdws_pkg::*;

  // Random requests after the directed set; the final stretch of them runs with no
  // idling on either side so that back-to-back frames are seen at full rate.
  localparam int RandRequests  = 370;
  localparam int TailRequests  = 40;
  // Long receiver hold-off: far longer than one 49-symbol frame, so the block ends up
  // with a frame stalled part way and a request waiting, and must drop in_ready.
  localparam int HoldOffCycles = 400;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  sym_t out_data;

  int   fail_count;
  int   pending_syms;

  // Flags shared between the stimulus and the receiver pacing process.
  bit   hold_off_go   = 1'b0;
  bit   hold_off_done = 1'b0;
  bit   tail_phase    = 1'b0;

  i2c_dac_write_sequencer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  i2cdws_symbol_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .pending_syms_o (pending_syms)
  );

  // 50 MHz clock.
  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Hard stop: the slowest legal run (every symbol stalled as long as the receiver pacing allows,
  // every request preceded by the longest sender gap) is well under a quarter of this.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic req_t mk_req(input logic [7:0] addr, input logic [11:0] code,
                                  input logic [7:0] cmd);
    req_t r;
    r.device_address = addr;
    r.dac_code       = code;
    r.command_byte   = cmd;
    return r;
  endfunction

  // Offer one request and hold it until the transaction completes. Valid is left high
  // on return; the caller's pause decides whether it drops, so the line never sees a
  // lower-and-raise within one time step.
  task automatic send_request(input req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender idling: half the time none, otherwise valid drops for a random gap so that
  // the next request turns up at varying points of the current frame.
  task automatic sender_pause();
    int gap;
    gap = 0;
    if (!tail_phase && $urandom_range(0, 1) == 1) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver pacing. Each branch makes exactly one assignment to out_ready and then waits
  // on the clock before the next, so there is never more than one update per time step.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (tail_phase) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_off_go && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        // mostly short runs of ready, now and then a long clean stretch
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 150)) @(posedge clk);
        else repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    req_t directed[$];
    directed = {
      mk_req(8'h00, 12'h000, 8'h00),   // all zero
      mk_req(8'hFF, 12'hFFF, 8'hFF),   // all ones
      mk_req(8'hFF, 12'h000, 8'h00),   // address only
      mk_req(8'h00, 12'hFFF, 8'h00),   // full-scale code
      mk_req(8'h00, 12'h000, 8'hFF),   // command only
      mk_req(8'h00, 12'hF00, 8'h00),   // code high nibble only, merges with the C0 mark
      mk_req(8'h00, 12'h0FF, 8'h00),   // code low byte only
      mk_req(8'h01, 12'h100, 8'h80),   // R/W bit set, lone bits at byte edges
      mk_req(8'h80, 12'h001, 8'h01),
      mk_req(8'hFE, 12'h800, 8'h7F),
      mk_req(8'h7F, 12'h7FF, 8'hFE),
      mk_req(8'hA5, 12'h5A5, 8'h3C),   // alternating patterns
      mk_req(8'h5A, 12'hA5A, 8'hC3)
    };

    // Reset held low, then released on a falling edge away from sampling.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i]);
      sender_pause();
    end

    // The long hold-off starts with the random part; the sender keeps offering.
    hold_off_go = 1'b1;
    for (int i = 0; i < RandRequests; i++) begin
      if (i >= RandRequests - TailRequests) tail_phase = 1'b1;
      send_request(mk_req(8'($urandom), 12'($urandom), 8'($urandom)));
      if (!hold_off_done) begin
        // no gaps while the receiver is held off, so the input really backs up
      end else begin
        sender_pause();
      end
    end

    // Drop valid after the last transaction, wait for every symbol to drain, then keep
    // watching for anything stray to appear.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_syms != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending_syms == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
